### src/emg_window_feature_extractor_assert.svh
// Assertion macros for the EMG window feature extractor
`ifndef EMG_WINDOW_FEATURE_EXTRACTOR_ASSERT_SVH
`define EMG_WINDOW_FEATURE_EXTRACTOR_ASSERT_SVH
// implication checked every clock, disabled in reset
`define EWF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define EWF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/ewf_pkg.sv
// Types and constants for the EMG window feature extractor
package ewf_pkg;
    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 13;
    localparam int DZ_W     = 15;
    localparam int TH_W     = 16;
    localparam int MIN_WINDOW = 5;

    localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [1:0] REG_DEADZONE       = 2'd1;
    localparam logic [1:0] REG_TURN_THRESHOLD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_OUT
    } ewf_state_t;
endpackage

### src/emg_window_feature_extractor.sv
// EMG window feature extractor top level: accumulators, sequencer and shared divider
//
// Takes one word of CHANNELS signed Q1.15 samples (ch0 in the low bits) and keeps per
// channel the sum, waveform length, zero crossings and turns over a window of
// window_length samples. A sample word is taken and its channels are then processed in turn:
// one shared adder/compare unit handles one channel per cycle. At the window end one result word
// per channel is produced, channel 0 first, last set on the final one; the four
// quotients come from one shared restoring divider that yields one bit per cycle, and no
// new sample word is taken until the last result word of the window has been accepted.
`include "emg_window_feature_extractor_assert.svh"
module emg_window_feature_extractor
    import ewf_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int MAX_WINDOW = 4096,
    parameter int LAG        = 2,
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int OCH_W   = (CH_W > 2) ? CH_W : 2,
    localparam int OUT_RAW = OCH_W + 4*16,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [TH_W-1:0]                cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample_ch0 .. sample_chN-1, 16 bits each, lowest first
    input  logic [CHANNELS*SAMPLE_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // channel, mean_value, wave_length_rate, zero_cross_rate, turns_rate, zero fill
    output logic [OUT_W-1:0]               m_tdata,
    output logic                           m_tlast
);
    localparam int TAPS   = 2*LAG;
    localparam int IDX_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int LEN_W  = SAMPLE_W + 1 + IDX_W;
    localparam int CNT_W  = IDX_W;
    localparam int DVD_W  = (LEN_W > CNT_W + 16) ? LEN_W : CNT_W + 16;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;

    // configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic [DZ_W-1:0]   dz_reg;
    logic [TH_W-1:0]   th_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_W'(150);
            dz_reg   <= DZ_W'(33);
            th_reg   <= TH_W'(49);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW_LENGTH:  wlen_reg <= cfg_data[WLEN_W-1:0];
                REG_DEADZONE:       dz_reg   <= cfg_data[DZ_W-1:0];
                REG_TURN_THRESHOLD: th_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [IDX_W-1:0] w_eff;
    always_comb begin
        if (wlen_reg < WLEN_W'(MIN_WINDOW)) w_eff = IDX_W'(MIN_WINDOW);
        else if (32'(wlen_reg) > 32'(MAX_WINDOW)) w_eff = IDX_W'(MAX_WINDOW);
        else w_eff = IDX_W'(wlen_reg);
    end

    // state
    ewf_state_t state_reg, state_next;
    logic [CH_W-1:0]  ch_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CHANNELS*SAMPLE_W-1:0] samp_reg;
    logic signed [SAMPLE_W-1:0] dly_reg [CHANNELS][TAPS];
    logic signed [SUM_W-1:0] sum_reg [CHANNELS];
    logic [LEN_W-1:0] len_reg [CHANNELS];
    logic [CNT_W-1:0] zc_reg [CHANNELS];
    logic [CNT_W-1:0] tn_reg [CHANNELS];
    logic [1:0] feat_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [IDX_W:0]   rem_reg;
    logic             neg_reg;
    logic [15:0] res_reg [4];
    logic window_end;

    // shared per-channel datapath
    logic signed [SAMPLE_W-1:0] x, fst, mid;
    logic signed [SAMPLE_W+1:0] d1, d2, a1, a2;
    logic same, quiet, zc_hit, tn_hit;
    logic signed [SAMPLE_W:0] sdz;
    always_comb begin
        x   = samp_reg[ch_reg*SAMPLE_W +: SAMPLE_W];
        fst = dly_reg[ch_reg][TAP_W'(TAPS-1)];
        mid = dly_reg[ch_reg][TAP_W'(LAG-1)];
        sdz = $signed({2'b00, dz_reg});
        same = (mid >= 0 && fst >= 0) || (mid <= 0 && fst <= 0);
        quiet = (mid < sdz) && (mid > -sdz) && (fst < sdz) && (fst > -sdz);
        zc_hit = !same && !quiet;
        d1 = (SAMPLE_W+2)'(mid) - (SAMPLE_W+2)'(fst);
        d2 = (SAMPLE_W+2)'(mid) - (SAMPLE_W+2)'(x);
        a1 = d1[SAMPLE_W+1] ? -d1 : d1;
        a2 = d2[SAMPLE_W+1] ? -d2 : d2;
        tn_hit = ((mid > fst && mid > x) || (mid < fst && mid < x)) &&
                 (a1 > $signed({2'b00, th_reg}) || a2 > $signed({2'b00, th_reg}));
    end

    // divider operand
    logic [DVD_W-1:0] dvd;
    logic signed [SUM_W-1:0] s_sel;
    always_comb begin
        s_sel = sum_reg[ch_reg];
        case (feat_reg)
            2'd0: dvd = DVD_W'(s_sel[SUM_W-1] ? -s_sel : s_sel);
            2'd1: dvd = DVD_W'(len_reg[ch_reg]);
            2'd2: dvd = DVD_W'({zc_reg[ch_reg], 16'h0000});
            default: dvd = DVD_W'({tn_reg[ch_reg], 16'h0000});
        endcase
    end
    logic [IDX_W:0] rem_sh;
    logic [IDX_W:0] rem_sub;
    logic           fits;
    always_comb begin
        rem_sh  = {rem_reg[IDX_W-1:0], quo_reg[DVD_W-1]};
        fits    = rem_sh >= {1'b0, w_eff};
        rem_sub = rem_sh - {1'b0, w_eff};
    end
    logic [15:0] sat_q;
    always_comb begin
        if (feat_reg == 2'd0) begin
            if (neg_reg) sat_q = (quo_reg > DVD_W'(32768)) ? 16'h8000 : 16'(-quo_reg);
            else sat_q = (quo_reg > DVD_W'(32767)) ? 16'h7fff : quo_reg[15:0];
        end else begin
            sat_q = (quo_reg > DVD_W'(65535)) ? 16'hffff : quo_reg[15:0];
        end
    end

    assign window_end = (32'(idx_reg) + 1) >= 32'(w_eff);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_ACCUM;
            ST_ACCUM:    if (32'(ch_reg) == CHANNELS-1)
                             state_next = window_end ? ST_DIV_INIT : ST_IDLE;
            ST_DIV_INIT: state_next = ST_DIV_RUN;
            ST_DIV_RUN:  if (32'(step_reg) == DIV_STEPS-1) state_next = ST_DIV_DONE;
            ST_DIV_DONE: state_next = (feat_reg == 2'd3) ? ST_OUT : ST_DIV_INIT;
            ST_OUT:      if (m_tready)
                             state_next = (32'(ch_reg) == CHANNELS-1) ? ST_IDLE : ST_DIV_INIT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tlast  = m_tvalid && (32'(ch_reg) == CHANNELS-1);
        m_tdata  = OUT_W'({res_reg[3], res_reg[2], res_reg[1], res_reg[0],
                           OCH_W'(ch_reg)});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            idx_reg   <= '0;
            feat_reg  <= '0;
            step_reg  <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= '0; len_reg[c] <= '0; zc_reg[c] <= '0; tn_reg[c] <= '0;
                for (int t = 0; t < TAPS; t++) dly_reg[c][t] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    ch_reg <= '0;
                    if (s_tvalid) samp_reg <= s_tdata;
                end
                ST_ACCUM: begin
                    sum_reg[ch_reg] <= sum_reg[ch_reg] + SUM_W'(x);
                    if (32'(idx_reg) >= TAPS) begin
                        len_reg[ch_reg] <= len_reg[ch_reg] + LEN_W'(a1);
                        if (zc_hit) zc_reg[ch_reg] <= zc_reg[ch_reg] + 1'b1;
                        if (tn_hit) tn_reg[ch_reg] <= tn_reg[ch_reg] + 1'b1;
                    end
                    for (int t = TAPS-1; t > 0; t--)
                        dly_reg[ch_reg][t] <= dly_reg[ch_reg][t-1];
                    dly_reg[ch_reg][0] <= x;
                    if (32'(ch_reg) == CHANNELS-1) begin
                        ch_reg <= '0;
                        feat_reg <= '0;
                        if (!window_end) idx_reg <= idx_reg + 1'b1;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_DIV_INIT: begin
                    quo_reg  <= dvd;
                    rem_reg  <= '0;
                    step_reg <= '0;
                    neg_reg  <= (feat_reg == 2'd0) && s_sel[SUM_W-1];
                end
                ST_DIV_RUN: begin
                    rem_reg  <= fits ? rem_sub : rem_sh;
                    quo_reg  <= {quo_reg[DVD_W-2:0], fits};
                    step_reg <= step_reg + 1'b1;
                end
                ST_DIV_DONE: begin
                    res_reg[feat_reg] <= sat_q;
                    feat_reg <= feat_reg + 1'b1;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (32'(ch_reg) == CHANNELS-1) begin
                            ch_reg  <= '0;
                            idx_reg <= '0;
                            for (int c = 0; c < CHANNELS; c++) begin
                                sum_reg[c] <= '0; len_reg[c] <= '0;
                                zc_reg[c] <= '0; tn_reg[c] <= '0;
                                for (int t = 0; t < TAPS; t++) dly_reg[c][t] <= '0;
                            end
                        end else begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `EWF_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "in and out both open")
    `EWF_ASSERT_IMPL(a_last_ch, aclk, aresetn, m_tlast, 32'(ch_reg) == CHANNELS-1, "bad last")
    `EWF_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "hold")
    `EWF_ASSERT_IMPL(a_idx, aclk, aresetn, 1'b1, 32'(idx_reg) < MAX_WINDOW, "index overrun")
endmodule
